>>> rtl/rgtd_pkg.sv
// Shared types and constants for the RDS group text decoder.
package rgtd_pkg;

	// store sizes
	localparam int NAME_LEN  = 8;
	localparam int TEXT_LEN  = 64;
	localparam int TEXT_ROWS = TEXT_LEN / 4;
	localparam int NAME_IW   = $clog2(NAME_LEN);
	localparam int ROW_IW    = $clog2(TEXT_ROWS);
	localparam int TEXT_IW   = $clog2(TEXT_LEN);

	// operation codes
	localparam logic [1:0] OP_DECODE    = 2'd0;
	localparam logic [1:0] OP_READ_NAME = 2'd1;
	localparam logic [1:0] OP_READ_TEXT = 2'd2;

	// status codes
	localparam logic [1:0] ST_NO        = 2'd0;
	localparam logic [1:0] ST_AVAILABLE = 2'd1;
	localparam logic [1:0] ST_FAKE      = 2'd2;

	// group types carried in block B
	localparam logic [3:0] GT_NAME = 4'h0;
	localparam logic [3:0] GT_TEXT = 4'h2;

	// character acceptance window
	localparam logic [7:0] CH_LOW  = 8'h10;
	localparam logic [7:0] CH_HIGH = 8'h7F;
	localparam logic [7:0] CH_CR   = 8'h0D;

	typedef struct packed {
		logic [1:0]  operation;
		logic        group_ready;
		logic [15:0] block_b;
		logic [15:0] block_c;
		logic [15:0] block_d;
		logic [5:0]  char_index;
	} rgtd_in_t;

	typedef struct packed {
		logic [1:0] status;
		logic [5:0] text_position;
		logic       position_valid;
		logic [7:0] char_value;
	} rgtd_out_t;

	typedef enum logic [1:0] {
		KIND_DECODE  = 2'd0,
		KIND_RD_NAME = 2'd1,
		KIND_RD_TEXT = 2'd2,
		KIND_NOP     = 2'd3
	} rgtd_kind_t;

	// classified command passed from front to back through the queue
	typedef struct packed {
		rgtd_kind_t  kind;
		logic        group_ready;
		logic        is_name;
		logic        is_text;
		logic [1:0]  name_we;
		logic [3:0]  text_we;
		logic [3:0]  seg;
		logic [31:0] chars;
		logic [5:0]  char_index;
	} rgtd_cmd_t;

endpackage

>>> rtl/rds_group_text_decoder.sv
// Top level of the RDS group decoder for station name and radio text.
//
//  channel   | handshake            | payload
//  ----------+----------------------+----------------------------
//  input     | start / busy         | item   (rgtd_in_t)
//  result    | done (strobe)        | result (rgtd_out_t)
//
//  Each item yields one result after its transfer, passing first through the
//  command queue and then the back end's result stage, where the text memory read
//  is registered. One item per cycle is sustained while busy is low.
//  Reset clears the name store, the text valid bits and sets the fake flag.
//  busy rises only when the command queue is full; results cannot be held off.
module rds_group_text_decoder #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  rgtd_pkg::rgtd_in_t  item,
	output logic                done,
	output rgtd_pkg::rgtd_out_t result
);
	import rgtd_pkg::*;

	rgtd_cmd_t push_cmd;
	rgtd_cmd_t pop_cmd;
	logic      push;
	logic      pop;
	logic      q_empty;
	logic      q_full;

	// classify incoming items
	rgtd_front u_front (
		.start  (start),
		.item   (item),
		.q_full (q_full),
		.busy   (busy),
		.push   (push),
		.cmd    (push_cmd)
	);

	// decouple front and back
	rgtd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.empty    (q_empty),
		.full     (q_full),
		.pop_cmd  (pop_cmd)
	);

	// execute commands against the stores
	rgtd_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.cmd     (pop_cmd),
		.pop     (pop),
		.done    (done),
		.result  (result)
	);

endmodule

>>> rtl/rgtd_front.sv
// Front end: accepts items and classifies them into queue commands.
module rgtd_front (
	input  logic               start,
	input  rgtd_pkg::rgtd_in_t item,
	input  logic               q_full,
	output logic               busy,
	output logic               push,
	output rgtd_pkg::rgtd_cmd_t cmd
);
	import rgtd_pkg::*;

	function automatic logic char_ok(input logic [7:0] ch);
		char_ok = ((ch >= CH_LOW) && (ch <= CH_HIGH)) || (ch == CH_CR);
	endfunction

	logic [3:0] grp_type;
	logic       dec_rdy;

	assign busy     = q_full;
	assign push     = start && !q_full;
	assign grp_type = item.block_b[15:12];
	assign dec_rdy  = (item.operation == OP_DECODE) && item.group_ready;

	// classify operation and precompute per-byte write enables
	always_comb begin
		cmd = '0;
		case (item.operation)
			OP_DECODE:    cmd.kind = KIND_DECODE;
			OP_READ_NAME: cmd.kind = KIND_RD_NAME;
			OP_READ_TEXT: cmd.kind = KIND_RD_TEXT;
			default:      cmd.kind = KIND_NOP;
		endcase
		cmd.group_ready = dec_rdy;
		cmd.is_name     = dec_rdy && (grp_type == GT_NAME);
		cmd.is_text     = dec_rdy && (grp_type == GT_TEXT);
		cmd.seg         = item.block_b[3:0];
		cmd.chars       = {item.block_c, item.block_d};
		cmd.char_index  = item.char_index;
		// name segment takes both bytes of block D
		cmd.name_we[0]  = cmd.is_name && char_ok(item.block_d[15:8]);
		cmd.name_we[1]  = cmd.is_name && char_ok(item.block_d[7:0]);
		// text segment takes C high, C low, D high, D low
		cmd.text_we[0]  = cmd.is_text && char_ok(item.block_c[15:8]);
		cmd.text_we[1]  = cmd.is_text && char_ok(item.block_c[7:0]);
		cmd.text_we[2]  = cmd.is_text && char_ok(item.block_d[15:8]);
		cmd.text_we[3]  = cmd.is_text && char_ok(item.block_d[7:0]);
	end

endmodule

>>> rtl/rgtd_queue.sv
// Small command FIFO between the front and back ends.
module rgtd_queue #(
	parameter int DEPTH = 2
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  rgtd_pkg::rgtd_cmd_t push_cmd,
	input  logic                pop,
	output logic                empty,
	output logic                full,
	output rgtd_pkg::rgtd_cmd_t pop_cmd
);
	import rgtd_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

	rgtd_cmd_t        slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign empty   = (count_q == '0);
	assign full    = (count_q == CNT_W'(DEPTH));
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign pop_cmd = slot_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> rtl/rgtd_back.sv
// Back end: updates the name and text stores and forms results.
module rgtd_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_empty,
	input  rgtd_pkg::rgtd_cmd_t cmd,
	output logic                pop,
	output logic                done,
	output rgtd_pkg::rgtd_out_t result
);
	import rgtd_pkg::*;

	// name store in flops, text store as a row memory with per-byte valid bits
	logic [7:0]          name_q [NAME_LEN];
	logic [7:0]          name_d [NAME_LEN];
	logic [31:0]         text_mem [TEXT_ROWS];
	logic [TEXT_LEN-1:0] text_vld_q;
	logic                fake_q;

	logic                is_dec;
	logic                is_rd_name;
	logic                is_rd_text;
	logic [31:0]         wr_data;
	logic [ROW_IW-1:0]   rd_row;

	// result stage
	logic                valid_s2;
	logic [1:0]          status_s2;
	logic [5:0]          pos_s2;
	logic                pvalid_s2;
	logic [7:0]          name_char_s2;
	logic                rd_text_s2;
	logic [1:0]          byte_sel_s2;
	logic                byte_vld_s2;
	logic [31:0]         row_s2;

	assign pop        = !q_empty;
	assign is_dec     = pop && (cmd.kind == KIND_DECODE);
	assign is_rd_name = pop && (cmd.kind == KIND_RD_NAME);
	assign is_rd_text = pop && (cmd.kind == KIND_RD_TEXT);
	assign rd_row     = cmd.char_index[5:2];
	// row byte 0 holds C high, byte 3 holds D low
	assign wr_data    = {cmd.chars[7:0], cmd.chars[15:8], cmd.chars[23:16], cmd.chars[31:24]};

	// next name store: first real group wipes it, then the segment lands
	always_comb begin
		name_d = name_q;
		if (is_dec && cmd.group_ready && fake_q) begin
			for (int i = 0; i < NAME_LEN; i++) begin
				name_d[i] = '0;
			end
		end
		if (is_dec && cmd.name_we[0]) begin
			name_d[{cmd.seg[1:0], 1'b0}] = cmd.chars[15:8];
		end
		if (is_dec && cmd.name_we[1]) begin
			name_d[{cmd.seg[1:0], 1'b1}] = cmd.chars[7:0];
		end
	end

	// name store and fake flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NAME_LEN; i++) begin
				name_q[i] <= '0;
			end
			fake_q <= 1'b1;
		end else begin
			name_q <= name_d;
			if (is_dec && cmd.group_ready) begin
				fake_q <= 1'b0;
			end
		end
	end

	// text memory: one row write with byte enables, one registered row read
	always_ff @(posedge clk) begin
		for (int j = 0; j < 4; j++) begin
			if (is_dec && cmd.text_we[j]) begin
				text_mem[cmd.seg][8*j +: 8] <= wr_data[8*j +: 8];
			end
		end
		if (is_rd_text) begin
			row_s2 <= text_mem[rd_row];
		end
	end

	// text byte valid bits, cleared by reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_vld_q <= '0;
		end else begin
			for (int j = 0; j < 4; j++) begin
				if (is_dec && cmd.text_we[j]) begin
					text_vld_q[{cmd.seg, 2'(j)}] <= 1'b1;
				end
			end
		end
	end

	// result stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= pop;
		end
	end

	// result stage payload
	always_ff @(posedge clk) begin
		if (pop) begin
			status_s2    <= ST_NO;
			pos_s2       <= '0;
			pvalid_s2    <= 1'b0;
			name_char_s2 <= '0;
			rd_text_s2   <= is_rd_text;
			byte_sel_s2  <= cmd.char_index[1:0];
			byte_vld_s2  <= text_vld_q[cmd.char_index[TEXT_IW-1:0]];
			if (is_dec) begin
				// a change is a first real group or a name or text segment
				if (cmd.group_ready && (fake_q || cmd.is_name || cmd.is_text)) begin
					status_s2 <= ST_AVAILABLE;
				end
				if (cmd.is_text) begin
					pos_s2    <= {cmd.seg, 2'b00};
					pvalid_s2 <= 1'b1;
				end
			end
			if (is_rd_name && (cmd.char_index < 6'(NAME_LEN))) begin
				name_char_s2 <= name_q[cmd.char_index[NAME_IW-1:0]];
			end
		end
	end

	// output
	always_comb begin
		result                = '0;
		result.status         = status_s2;
		result.text_position  = pos_s2;
		result.position_valid = pvalid_s2;
		if (rd_text_s2) begin
			result.char_value = byte_vld_s2 ? row_s2[8*byte_sel_s2 +: 8] : 8'h00;
		end else begin
			result.char_value = name_char_s2;
		end
	end

	assign done = valid_s2;

endmodule

>>> rtl/rgtd_checker.sv
// Port-level assertions for the RDS group decoder, with bind.
module rgtd_props (
	input logic                clk,
	input logic                arst_n,
	input logic                start,
	input logic                busy,
	input rgtd_pkg::rgtd_in_t  item,
	input logic                done,
	input rgtd_pkg::rgtd_out_t result
);
	import rgtd_pkg::*;

	// every transfer is followed by a result
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##2 done)
		else $error("accepted item produced no result");

	// no result appears without a matching transfer
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 2))
		else $error("result without accepted item");

	// a text position is only reported for a text group, which is a change
	a_pos_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.position_valid) |->
		(result.status == ST_AVAILABLE && result.char_value == 8'h00))
		else $error("text position on a non-decode result");

	// a position is zero unless marked valid
	a_pos_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !result.position_valid) |-> (result.text_position == 6'd0))
		else $error("stray text position");

	// character reads carry no status
	a_read_status: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.char_value != 8'h00) |-> (result.status == ST_NO))
		else $error("status set on a character read");

endmodule

bind rds_group_text_decoder rgtd_props u_rgtd_props (.*);

>>> sim/rgtd_checker.sv
// Transfer monitor, behavioral prediction and result comparison for the RDS group decoder.
`timescale 1ns / 100ps

module rgtd_checker
	import rgtd_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  logic      busy,
	input  rgtd_in_t  item,
	input  logic      done,
	input  rgtd_out_t result,
	output int        errors,
	output int        pending
);

	// predicted decoder state
	logic [7:0] station_name [NAME_LEN];
	logic [7:0] radio_text [TEXT_LEN];
	logic       no_real_group;
	logic       change_marked;

	// expected results, oldest first
	rgtd_out_t  expected_q [$];
	int         result_no;

	initial begin
		foreach (station_name[i]) station_name[i] = '0;
		foreach (radio_text[i]) radio_text[i] = '0;
		no_real_group = 1'b1;
		change_marked = 1'b0;
		errors = 0;
		pending = 0;
		result_no = 0;
	end

	// one line per failure, counted for the verdict
	task automatic note_failure(input string what);
		$display("%0t ns result %0d: %s", $time, result_no, what);
		errors++;
	endtask

	// only characters from 0x10 to 0x7F and carriage return are stored
	function automatic logic storable(input logic [7:0] ch);
		return (ch >= CH_LOW && ch <= CH_HIGH) || ch == CH_CR;
	endfunction

	// apply one command to the predicted state and return its result
	function automatic rgtd_out_t decode_step(input rgtd_in_t it);
		rgtd_out_t  r;
		logic [3:0] gtype;
		logic [5:0] base;
		logic [7:0] chars [4];
		r = '0;
		gtype = it.block_b[15:12];
		chars[0] = it.block_c[15:8];
		chars[1] = it.block_c[7:0];
		chars[2] = it.block_d[15:8];
		chars[3] = it.block_d[7:0];
		case (it.operation)
			OP_DECODE: begin
				if (it.group_ready) begin
					// first real group wipes the name
					if (no_real_group) begin
						foreach (station_name[i]) station_name[i] = '0;
						change_marked = 1'b1;
					end
					no_real_group = 1'b0;
					if (gtype == GT_NAME) begin
						base = {3'b000, it.block_b[1:0], 1'b0};
						for (int k = 0; k < 2; k++)
							if (storable(chars[2 + k]))
								station_name[NAME_IW'(base + k)] = chars[2 + k];
						change_marked = 1'b1;
					end else if (gtype == GT_TEXT) begin
						base = {it.block_b[3:0], 2'b00};
						change_marked = 1'b1;
						r.text_position = base;
						r.position_valid = 1'b1;
						for (int k = 0; k < 4; k++)
							if (storable(chars[k]))
								radio_text[TEXT_IW'(base + k)] = chars[k];
					end
				end
				if (change_marked)
					r.status = no_real_group ? ST_FAKE : ST_AVAILABLE;
				else
					r.status = ST_NO;
				change_marked = 1'b0;
			end
			OP_READ_NAME: begin
				if (it.char_index < NAME_LEN)
					r.char_value = station_name[it.char_index[NAME_IW-1:0]];
			end
			OP_READ_TEXT: begin
				r.char_value = radio_text[it.char_index];
			end
			default: ;
		endcase
		return r;
	endfunction

	// watch both channels on each rising edge
	always @(posedge clk) begin
		rgtd_out_t want;
		if (arst_n) begin
			if (start && !busy) expected_q.push_back(decode_step(item));
			if (done) begin
				if (expected_q.size() == 0) begin
					note_failure("result with no command outstanding");
				end else begin
					want = expected_q.pop_front();
					if (result.status !== want.status)
						note_failure($sformatf("status %0d, expected %0d",
							result.status, want.status));
					if (result.text_position !== want.text_position)
						note_failure($sformatf("text_position %0d, expected %0d",
							result.text_position, want.text_position));
					if (result.position_valid !== want.position_valid)
						note_failure($sformatf("position_valid %0d, expected %0d",
							result.position_valid, want.position_valid));
					if (result.char_value !== want.char_value)
						note_failure($sformatf("char_value %h, expected %h",
							result.char_value, want.char_value));
				end
				result_no++;
			end
			pending = expected_q.size();
		end
	end

endmodule

>>> sim/tb.sv
// Testbench top: clock, reset, command stimulus, watchdog and verdict for the RDS group decoder.
`timescale 1ns / 100ps

module tb;
	import rgtd_pkg::*;

	localparam int STALL_LIMIT = 2000;
	localparam int PHASE_ITEMS = 400;

	logic      clk;
	logic      arst_n;
	logic      start;
	logic      busy;
	rgtd_in_t  item;
	logic      done;
	rgtd_out_t result;
	int        errors;
	int        pending;
	int        send_idle_pct;

	rds_group_text_decoder u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.item   (item),
		.done   (done),
		.result (result)
	);

	rgtd_checker u_checker (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.item    (item),
		.done    (done),
		.result  (result),
		.errors  (errors),
		.pending (pending)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// give up when no transfer happens on either channel for too long
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((start && !busy) || done) quiet = 0;
			else quiet++;
		end
		$display("RESULT: ERROR");
		$finish;
	end

	function automatic rgtd_in_t make_cmd(input logic [1:0] op, input logic rdy,
		input logic [15:0] b, input logic [15:0] c, input logic [15:0] d,
		input logic [5:0] idx);
		rgtd_in_t it;
		it.operation = op;
		it.group_ready = rdy;
		it.block_b = b;
		it.block_c = c;
		it.block_d = d;
		it.char_index = idx;
		return it;
	endfunction

	// mostly printable text, some carriage returns, some arbitrary bytes
	function automatic logic [7:0] text_char();
		int r;
		r = $urandom_range(9);
		if (r < 7) return 8'($urandom_range(8'h7E, 8'h20));
		if (r == 7) return CH_CR;
		return 8'($urandom);
	endfunction

	// well-formed groups and reads dominate; the rest is noise
	function automatic rgtd_in_t random_cmd();
		rgtd_in_t   it;
		int         pick;
		int         tsel;
		logic [3:0] gtype;
		it = make_cmd(2'($urandom), 1'($urandom), 16'($urandom), 16'($urandom),
			16'($urandom), 6'($urandom));
		pick = $urandom_range(99);
		if (pick < 45) begin
			tsel = $urandom_range(9);
			gtype = (tsel < 5) ? GT_NAME : (tsel < 9) ? GT_TEXT : 4'($urandom);
			it.operation = OP_DECODE;
			it.group_ready = ($urandom_range(9) != 0);
			it.block_b[15:12] = gtype;
			it.block_c = {text_char(), text_char()};
			it.block_d = {text_char(), text_char()};
		end else if (pick < 65) begin
			it.operation = OP_READ_NAME;
			if ($urandom_range(3) != 0) it.char_index = 6'($urandom_range(NAME_LEN - 1));
		end else if (pick < 92) begin
			it.operation = OP_READ_TEXT;
		end
		return it;
	endfunction

	// one command transfer, with random sender gaps ahead of it
	task automatic send(input rgtd_in_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		item <= it;
		do @(posedge clk); while (busy);
		@(negedge clk);
	endtask

	initial begin : stimulus
		start = 1'b0;
		item = '0;
		arst_n = 1'b0;
		send_idle_pct = 19;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// empty stores, idle decode, unused opcode
		send(make_cmd(OP_READ_NAME, 1'b0, 16'h0000, 16'h0000, 16'h0000, 6'd0));
		send(make_cmd(OP_READ_TEXT, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 6'd63));
		send(make_cmd(OP_DECODE, 1'b0, 16'h2FFF, 16'h4142, 16'h4344, 6'd63));
		send(make_cmd(2'd3, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 6'd63));
		// first real group of an unhandled type, then nothing new
		send(make_cmd(OP_DECODE, 1'b1, 16'h5ABC, 16'h4142, 16'h4344, 6'd0));
		send(make_cmd(OP_DECODE, 1'b0, 16'h0000, 16'h0000, 16'h4142, 6'd0));
		// station name segments, window edges on both sides
		send(make_cmd(OP_DECODE, 1'b1, 16'h0000, 16'h0000, 16'h4142, 6'd0));
		send(make_cmd(OP_DECODE, 1'b1, 16'h0FFF, 16'hFFFF, 16'h0D0F, 6'd63));
		send(make_cmd(OP_DECODE, 1'b1, 16'h0001, 16'h0000, 16'h107F, 6'd0));
		send(make_cmd(OP_DECODE, 1'b1, 16'h0002, 16'h0000, 16'h80FF, 6'd0));
		send(make_cmd(OP_DECODE, 1'b1, 16'h000E, 16'h0000, 16'h0000, 6'd0));
		// radio text at first and last segment, then all rejected
		send(make_cmd(OP_DECODE, 1'b1, 16'h2000, 16'h2021, 16'h7E7F, 6'd0));
		send(make_cmd(OP_DECODE, 1'b1, 16'h2FFF, 16'h0D10, 16'h0F80, 6'd0));
		send(make_cmd(OP_DECODE, 1'b1, 16'h200A, 16'hFFFF, 16'h0000, 6'd0));
		// other group type after the first one
		send(make_cmd(OP_DECODE, 1'b1, 16'hF000, 16'h4142, 16'h4344, 6'd0));
		// reads at the edges of both stores
		send(make_cmd(OP_READ_NAME, 1'b0, 16'h0000, 16'h0000, 16'h0000, 6'd7));
		send(make_cmd(OP_READ_NAME, 1'b0, 16'h0000, 16'h0000, 16'h0000, 6'd6));
		send(make_cmd(OP_READ_NAME, 1'b0, 16'h0000, 16'h0000, 16'h0000, 6'd8));
		send(make_cmd(OP_READ_NAME, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 6'd63));
		send(make_cmd(OP_READ_TEXT, 1'b0, 16'h0000, 16'h0000, 16'h0000, 6'd0));
		send(make_cmd(OP_READ_TEXT, 1'b0, 16'h0000, 16'h0000, 16'h0000, 6'd60));
		send(make_cmd(OP_READ_TEXT, 1'b0, 16'h0000, 16'h0000, 16'h0000, 6'd63));
		send(make_cmd(OP_READ_TEXT, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 6'd40));

		// random traffic under three sender gap rates
		for (int n = 0; n < PHASE_ITEMS; n++) send(random_cmd());
		send_idle_pct = 71;
		for (int n = 0; n < PHASE_ITEMS; n++) send(random_cmd());
		send_idle_pct = 0;
		for (int n = 0; n < PHASE_ITEMS; n++) send(random_cmd());
		start <= 1'b0;

		// drain, then allow for the command queue and result stage to empty
		while (pending != 0) @(negedge clk);
		repeat (8) @(negedge clk);
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

>>> filelist.f
rtl/rgtd_pkg.sv
rtl/rgtd_front.sv
rtl/rgtd_queue.sv
rtl/rgtd_back.sv
rtl/rds_group_text_decoder.sv
rtl/rgtd_checker.sv
sim/rgtd_checker.sv
sim/tb.sv
